### rtl/utf8_stream_decoder_assert.svh
// assertion macros for the utf8 stream decoder checker
// depends on nothing; included by the checker file
`ifndef UTF8_STREAM_DECODER_ASSERT_SVH
`define UTF8_STREAM_DECODER_ASSERT_SVH

// same-cycle implication, reset masked
`define UTF8SD_ASSERT_NOW(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, reset masked
`define UTF8SD_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

### rtl/utf8sd_pkg.sv
// shared types and constants for the utf8 stream decoder
// no dependencies
package utf8sd_pkg;

    localparam logic [31:0] ERROR_VALUE_RST = 32'h0000_FFFD;
    localparam int          RES_FIFO_DEPTH  = 4;

    // lead byte ranges
    localparam logic [7:0] ASCII_LIMIT   = 8'h80;
    localparam logic [7:0] LEAD_2B       = 8'hC0;
    localparam logic [7:0] LEAD_3B       = 8'hE0;
    localparam logic [7:0] LEAD_4B       = 8'hF0;
    localparam logic [7:0] LEAD_LONG     = 8'hF8;
    localparam logic [7:0] LEAD_LONG_MAX = 8'hFD;
    localparam logic [1:0] CONT_TAG      = 2'b10;
    localparam logic [7:0] SAT_MAX       = 8'hFF;

    // code point bounds
    localparam logic [20:0] MIN_2B  = 21'h00080;
    localparam logic [20:0] MIN_3B  = 21'h00800;
    localparam logic [20:0] MIN_4B  = 21'h10000;
    localparam logic [20:0] MAX_CP  = 21'h10FFFF;
    localparam logic [20:0] SURR_LO = 21'h0D800;
    localparam logic [20:0] SURR_HI = 21'h0DFFF;

    typedef struct packed {
        logic [2:0]  expected;
        logic [7:0]  taken;
        logic [20:0] acc;
        logic        bad;
        logic        long_mode;
    } t_slice_state;

    typedef struct packed {
        logic        err;
        logic [20:0] cp;
        logic [7:0]  nbytes;
        logic        last;
    } t_result;

    typedef struct packed {
        logic    v0;
        logic    v1;
        t_result r0;
        t_result r1;
    } t_push;

    typedef struct packed {
        logic not_empty;
        logic room_two;
    } t_fifo_status;

endpackage

### rtl/utf8sd_byte_if.sv
// byte stream channel of the utf8 stream decoder
// no dependencies
interface utf8sd_byte_if;
    logic       valid;
    logic       ready;
    logic [7:0] data_byte;
    logic       end_of_buffer;

    modport source (output valid, output data_byte, output end_of_buffer, input ready);
    modport sink (input valid, input data_byte, input end_of_buffer, output ready);
endinterface

### rtl/utf8sd_res_if.sv
// result channel of the utf8 stream decoder
// no dependencies
interface utf8sd_res_if;
    logic        valid;
    logic        ready;
    logic [31:0] code_point;
    logic        is_error;
    logic [7:0]  slice_bytes;
    logic        last_of_run;

    modport source (output valid, output code_point, output is_error, output slice_bytes,
                    output last_of_run, input ready);
    modport sink (input valid, input code_point, input is_error, input slice_bytes,
                  input last_of_run, output ready);
endinterface

### rtl/utf8sd_cfg_if.sv
// error value write channel of the utf8 stream decoder
// no dependencies
interface utf8sd_cfg_if;
    logic        valid;
    logic        ready;
    logic [31:0] data;

    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

### rtl/utf8_stream_decoder.sv
// channel    | dir | payload                                          | accepted when
// i_byte     | in  | data_byte[7:0], end_of_buffer                    | valid & ready
// o_res      | out | code_point[31:0], is_error, slice_bytes[7:0],    | valid & ready
//            |     | last_of_run                                      |
// i_cfg      | in  | data[31:0] -> error value                        | valid & ready
//
// one byte a cycle while the result queue has room for two: a byte beat lands in
// the input register, is decoded there and its one or two results go into the
// result queue, so a result is valid on o_res only after passing the input
// register and then the result queue
// a byte causing two results takes two o_res beats; the single output
// port of the result queue sets the sustained rate
// synchronous active-low reset clears input valid, slice state and queue and presets the error value
// o_res stalls only back up into i_byte once the queue has no room for two
module utf8_stream_decoder #(
    parameter int RES_DEPTH = utf8sd_pkg::RES_FIFO_DEPTH
) (
    input  logic           i_clk,
    input  logic           i_rst_n,
    utf8sd_byte_if.sink    i_byte,
    utf8sd_res_if.source   o_res,
    utf8sd_cfg_if.sink     i_cfg
);

    // input register
    logic        r_in_vld;
    logic [7:0]  r_in_byte;
    logic        r_in_eob;
    logic        step;
    logic        in_take;

    // error value register
    logic [31:0] r_err_val;

    utf8sd_pkg::t_push        push;
    utf8sd_pkg::t_result      head;
    utf8sd_pkg::t_fifo_status fifo_st;
    logic                     pop;

    // decode the held byte only when the queue can take both possible results
    assign step    = r_in_vld & fifo_st.room_two;
    assign in_take = i_byte.valid & i_byte.ready;

    // free, or emptying this cycle
    assign i_byte.ready = ~r_in_vld | step;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_vld <= 1'b0;
        end else if (i_byte.ready) begin
            r_in_vld <= i_byte.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_take) begin
            r_in_byte <= i_byte.data_byte;
            r_in_eob  <= i_byte.end_of_buffer;
        end
    end

    // config beats are always taken; the user must make writes only arrive while idle, the block does not enforce it
    assign i_cfg.ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_err_val <= utf8sd_pkg::ERROR_VALUE_RST;
        end else if (i_cfg.valid) begin
            r_err_val <= i_cfg.data;
        end
    end

    utf8sd_decode u_decode (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_step  (step),
        .i_byte  (r_in_byte),
        .i_eob   (r_in_eob),
        .o_push  (push)
    );

    assign pop = o_res.valid & o_res.ready;

    utf8sd_result_fifo #(
        .DEPTH (RES_DEPTH)
    ) u_fifo (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_push   (push),
        .i_pop    (pop),
        .o_head   (head),
        .o_status (fifo_st)
    );

    // error value substituted on the way out
    assign o_res.valid       = fifo_st.not_empty;
    assign o_res.code_point  = head.err ? r_err_val : {11'b0, head.cp};
    assign o_res.is_error    = head.err;
    assign o_res.slice_bytes = head.nbytes;
    assign o_res.last_of_run = head.last;

endmodule

### rtl/utf8sd_decode.sv
// slice state registers and per-byte decode logic
// depends on utf8sd_pkg
module utf8sd_decode (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_step,
    input  logic [7:0]          i_byte,
    input  logic                i_eob,
    output utf8sd_pkg::t_push   o_push
);

    typedef struct packed {
        utf8sd_pkg::t_slice_state st;
        logic                     emit;
        utf8sd_pkg::t_result      res;
    } t_start;

    // a new slice opened by lead byte b; any other byte gives a one-byte result at once
    function automatic t_start f_start(input logic [7:0] b, input logic eob);
        t_start s;
        s = '0;
        if (!(b inside {[utf8sd_pkg::LEAD_2B:utf8sd_pkg::LEAD_LONG_MAX]})) begin
            s.emit       = 1'b1;
            s.res.err    = (b >= utf8sd_pkg::ASCII_LIMIT);
            s.res.cp     = {13'b0, b};
            s.res.nbytes = 8'd1;
        end else begin
            s.st.taken = 8'd1;
            if (b < utf8sd_pkg::LEAD_3B) begin
                s.st.expected = 3'd2;
                s.st.acc      = {16'b0, b[4:0]};
            end else if (b < utf8sd_pkg::LEAD_4B) begin
                s.st.expected = 3'd3;
                s.st.acc      = {17'b0, b[3:0]};
            end else if (b < utf8sd_pkg::LEAD_LONG) begin
                s.st.expected = 3'd4;
                s.st.acc      = {18'b0, b[2:0]};
            end else begin
                s.st.long_mode = 1'b1;
            end
            if (eob) begin
                s.st         = '0;
                s.emit       = 1'b1;
                s.res.err    = 1'b1;
                s.res.nbytes = 8'd1;
            end
        end
        return s;
    endfunction

    utf8sd_pkg::t_slice_state r_state;
    utf8sd_pkg::t_slice_state n_state;
    t_start                   start;
    logic                     is_cont;
    logic [7:0]               taken_sat;
    logic [7:0]               taken_inc;
    logic [20:0]              acc_n;
    logic                     bad_n;
    logic [20:0]              lo_bound;
    logic                     legal;

    assign is_cont   = (i_byte[7:6] == utf8sd_pkg::CONT_TAG);
    assign taken_sat = (r_state.taken == utf8sd_pkg::SAT_MAX) ? r_state.taken
                                                              : r_state.taken + 8'd1;
    assign taken_inc = r_state.taken + 8'd1;
    assign acc_n     = {r_state.acc[14:0], i_byte[5:0]};
    assign bad_n     = r_state.bad | ~is_cont;
    assign legal     = (acc_n <= utf8sd_pkg::MAX_CP) &&
                       !(acc_n inside {[utf8sd_pkg::SURR_LO:utf8sd_pkg::SURR_HI]});

    always_comb begin
        case (r_state.expected)
            3'd2:    lo_bound = utf8sd_pkg::MIN_2B;
            3'd3:    lo_bound = utf8sd_pkg::MIN_3B;
            default: lo_bound = utf8sd_pkg::MIN_4B;
        endcase
    end

    always_comb begin
        start   = f_start(i_byte, i_eob);
        n_state = r_state;
        o_push  = '0;
        if (r_state.long_mode) begin
            if (is_cont) begin
                n_state.taken = taken_sat;
                if (i_eob) begin
                    n_state          = '0;
                    o_push.v0        = 1'b1;
                    o_push.r0.err    = 1'b1;
                    o_push.r0.nbytes = taken_sat;
                end
            end else begin
                // run closes, then this byte opens a slice of its own
                o_push.v0        = 1'b1;
                o_push.r0.err    = 1'b1;
                o_push.r0.nbytes = r_state.taken;
                n_state          = start.st;
                o_push.v1        = start.emit;
                o_push.r1        = start.res;
            end
        end else if (r_state.expected != 3'd0) begin
            n_state.acc   = acc_n;
            n_state.bad   = bad_n;
            n_state.taken = taken_inc;
            if (taken_inc >= {5'b0, r_state.expected}) begin
                n_state          = '0;
                o_push.v0        = 1'b1;
                o_push.r0.err    = bad_n | (acc_n < lo_bound) | ~legal;
                o_push.r0.cp     = acc_n;
                o_push.r0.nbytes = taken_inc;
            end else if (i_eob) begin
                n_state          = '0;
                o_push.v0        = 1'b1;
                o_push.r0.err    = 1'b1;
                o_push.r0.nbytes = taken_inc;
            end
        end else begin
            n_state   = start.st;
            o_push.v0 = start.emit;
            o_push.r0 = start.res;
        end
        o_push.r0.last = ~o_push.v1;
        o_push.r1.last = 1'b1;
        if (!i_step) begin
            o_push.v0 = 1'b0;
            o_push.v1 = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= '0;
        end else if (i_step) begin
            r_state <= n_state;
        end
    end

endmodule

### rtl/utf8sd_result_fifo.sv
// result queue taking up to two results a cycle and giving one
// depends on utf8sd_pkg
module utf8sd_result_fifo #(
    parameter int DEPTH = utf8sd_pkg::RES_FIFO_DEPTH
) (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  utf8sd_pkg::t_push        i_push,
    input  logic                     i_pop,
    output utf8sd_pkg::t_result      o_head,
    output utf8sd_pkg::t_fifo_status o_status
);

    localparam int PTR_W = $clog2(DEPTH);
    localparam int CNT_W = $clog2(DEPTH + 1);

    function automatic logic [PTR_W-1:0] f_inc(input logic [PTR_W-1:0] p);
        return (p == PTR_W'(DEPTH - 1)) ? '0 : p + PTR_W'(1);
    endfunction

    utf8sd_pkg::t_result r_mem [DEPTH];
    logic [PTR_W-1:0]    r_wr_ptr;
    logic [PTR_W-1:0]    n_wr_ptr;
    logic [PTR_W-1:0]    wr_ptr1;
    logic [PTR_W-1:0]    r_rd_ptr;
    logic [PTR_W-1:0]    n_rd_ptr;
    logic [CNT_W-1:0]    r_count;
    logic [CNT_W-1:0]    n_count;
    logic [1:0]          push_n;

    assign wr_ptr1 = f_inc(r_wr_ptr);
    assign push_n  = {1'b0, i_push.v0} + {1'b0, i_push.v1};

    always_comb begin
        n_wr_ptr = r_wr_ptr;
        if (i_push.v1) begin
            n_wr_ptr = f_inc(wr_ptr1);
        end else if (i_push.v0) begin
            n_wr_ptr = wr_ptr1;
        end
        n_rd_ptr = i_pop ? f_inc(r_rd_ptr) : r_rd_ptr;
        n_count  = r_count + CNT_W'(push_n) - CNT_W'(i_pop);
    end

    always_ff @(posedge i_clk) begin
        if (i_push.v0) begin
            r_mem[r_wr_ptr] <= i_push.r0;
        end
        if (i_push.v1) begin
            r_mem[wr_ptr1] <= i_push.r1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

    assign o_head             = r_mem[r_rd_ptr];
    assign o_status.not_empty = (r_count != '0);
    assign o_status.room_two  = (r_count <= CNT_W'(DEPTH - 2));

endmodule

### rtl/utf8sd_checker.sv
// port-level checks on the utf8 stream decoder result channel
// depends on utf8sd_pkg and utf8_stream_decoder_assert.svh
`include "utf8_stream_decoder_assert.svh"

module utf8sd_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        i_res_valid,
    input logic        i_res_ready,
    input logic [31:0] i_code_point,
    input logic        i_is_error,
    input logic [7:0]  i_slice_bytes
);

    // a stalled beat keeps its payload
    `UTF8SD_ASSERT_NEXT(a_res_hold, i_clk, i_rst_n, i_res_valid && !i_res_ready, i_res_valid && $stable(i_code_point) && $stable(i_slice_bytes) && $stable(i_is_error), "result beat changed while stalled")

    // every slice holds at least one byte
    `UTF8SD_ASSERT_NOW(a_nonzero_len, i_clk, i_rst_n, i_res_valid, i_slice_bytes != 8'd0, "slice of zero bytes")

    // good slices are at most four bytes with a code point no higher than MAX_CP
    `UTF8SD_ASSERT_NOW(a_good_slice, i_clk, i_rst_n, i_res_valid && !i_is_error, (i_slice_bytes <= 8'd4) && (i_code_point <= {11'b0, utf8sd_pkg::MAX_CP}), "good slice out of range")

    // good single bytes are plain ascii
    `UTF8SD_ASSERT_NOW(a_good_ascii, i_clk, i_rst_n, i_res_valid && !i_is_error && (i_slice_bytes == 8'd1), i_code_point < {24'b0, utf8sd_pkg::ASCII_LIMIT}, "single-byte slice not ascii")

endmodule

bind utf8_stream_decoder utf8sd_checker u_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .i_res_valid   (o_res.valid),
    .i_res_ready   (o_res.ready),
    .i_code_point  (o_res.code_point),
    .i_is_error    (o_res.is_error),
    .i_slice_bytes (o_res.slice_bytes)
);
